// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the byte budget LFU cache policy RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BBL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define BBL_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`define BBL_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define BBL_ASSERT(label, prop)
`define BBL_ASSERT_IMPL(label, pre, post)
`define BBL_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hw/rtl/bbl_pkg.sv
// Types and constants for the byte budget LFU cache policy core.
// No dependencies; imported by the cell, the top level and the testbench.
package bbl_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] BUDGET_RESET = 32'd1048576;
   localparam logic [4:0] EVICT_MAX = 5'd31;

   typedef enum logic [1:0] {
      OP_GET      = 2'd0,
      OP_PUT      = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_CLEAR,
      CELL_DROP,
      CELL_INSERT,
      CELL_TOUCH
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SCAN
   } fsm_type;

   typedef struct packed {
      op_type      operation;
      logic [63:0] key_tag;
      logic [31:0] object_bytes;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        stored;
      logic [4:0]  evicted_count;
      logic [31:0] entry_use_count;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] bytes_in_use;
      logic [4:0]  entries_in_use;
   } rsp_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic [63:0]  key;
      logic [31:0]  bytes;
      logic [63:0]  stamp;
   } cell_ctl_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] uses;
      logic [63:0] stamp;
      logic [31:0] bytes;
   } cand_type;

endpackage

// File: hw/rtl/bbl_cell.sv
// One table slot of the cache policy plus one stage of the victim search chain.
// Depends on bbl_pkg.
module bbl_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bbl_pkg::cell_ctl_type ctl,
   input  logic                  sel,
   input  bbl_pkg::cand_type     cand_in,
   input  logic [IW-1:0]         idx_in,
   output bbl_pkg::cand_type     cand_out,
   output logic [IW-1:0]         idx_out,
   output logic                  valid,
   output logic                  match,
   output logic [31:0]           bytes,
   output logic [31:0]           uses
);
   import bbl_pkg::*;

   logic        valid_ff, valid_in;
   logic [63:0] key_ff;
   logic [31:0] bytes_ff;
   logic [31:0] uses_ff;
   logic [63:0] stamp_ff;
   cand_type    cand_ff, cand_in_w;
   logic [IW-1:0] idx_ff, idx_in_w;
   logic        take_own;

   always_comb begin
      valid_in = valid_ff;
      case (ctl.cmd)
         CELL_CLEAR:  valid_in = 1'b0;
         CELL_DROP:   if (sel) valid_in = 1'b0;
         CELL_INSERT: if (sel) valid_in = 1'b1;
         default:     valid_in = valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && ctl.cmd == CELL_INSERT) begin
         key_ff   <= ctl.key;
         bytes_ff <= ctl.bytes;
         uses_ff  <= 32'd1;
         stamp_ff <= ctl.stamp;
      end else if (sel && ctl.cmd == CELL_TOUCH) begin
         if (!(&uses_ff)) begin
            uses_ff <= uses_ff + 32'd1;
         end
         stamp_ff <= ctl.stamp;
      end
   end

   // The lower slot wins ties because it entered the chain first.
   always_comb begin
      take_own = valid_ff && (!cand_in.valid || uses_ff < cand_in.uses ||
                 (uses_ff == cand_in.uses && stamp_ff < cand_in.stamp));
      if (take_own) begin
         cand_in_w = '{valid: 1'b1, uses: uses_ff, stamp: stamp_ff, bytes: bytes_ff};
         idx_in_w  = IW'(INDEX);
      end else begin
         cand_in_w = cand_in;
         idx_in_w  = idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
         idx_ff  <= '0;
      end else begin
         cand_ff <= cand_in_w;
         idx_ff  <= idx_in_w;
      end
   end

   assign cand_out = cand_ff;
   assign idx_out  = idx_ff;
   assign valid    = valid_ff;
   assign match    = valid_ff && key_ff == ctl.key;
   assign bytes    = bytes_ff;
   assign uses     = uses_ff;

endmodule

// File: hw/rtl/byte_budget_lfu_cache_policy_core.sv
// Top level of the byte budget LFU cache policy: control sequencer and cell chain.
// Depends on bbl_pkg, bbl_cell and assert_macros.svh.
//
// A command is taken when start is high and busy is low; req_payload carries the
// operation, key tag and object size. One result per command appears on
// rsp_payload for exactly one cycle with rsp_strobe high, and the receiver has no
// way to hold it off. Get, contains, clear and a refused put raise the strobe from the
// execute state. A put that may fit goes on to the check state, which stores it if it
// fits; each eviction adds a scan state, in which the minimum search ripples through
// the chain of slot cells at one cell per cycle, and a return to the check state.
// Busy stays high until the result is shown; a new command may be taken in the
// strobe cycle. The user must write the byte budget through csr_write_enable and
// csr_write_data only while the block is idle; the block does not enforce this.
// Reset empties the table, clears the statistics and the use counter, and sets
// the budget to 1048576 bytes; the table is usable in the cycle after reset.
`include "assert_macros.svh"
module byte_budget_lfu_cache_policy_core #(
   parameter int SLOTS = bbl_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bbl_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output bbl_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data
);
   import bbl_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW = $clog2(SLOTS + 1);

   fsm_type     state_ff, state_in;
   req_type     req_ff;
   logic [31:0] budget_ff;
   logic [31:0] byte_total_ff, byte_total_in;
   logic [EW-1:0] entries_ff, entries_in;
   logic [63:0] use_clock_ff, use_clock_in;
   logic [31:0] hit_total_ff, hit_total_in;
   logic [31:0] miss_total_ff, miss_total_in;
   logic        hit_ff, hit_in;
   logic        stored_ff, stored_in;
   logic [4:0]  evicted_ff, evicted_in;
   logic [31:0] use_out_ff, use_out_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic        strobe_ff, strobe_in;

   cell_ctl_type ctl;
   logic [SLOTS-1:0] sel;
   logic [SLOTS-1:0] valid_w, match_w;
   logic [31:0]      bytes_w [SLOTS];
   logic [31:0]      uses_w  [SLOTS];
   cand_type         cand_w  [SLOTS+1];
   logic [IW-1:0]    idx_w   [SLOTS+1];

   logic [SLOTS-1:0] match_first, free_first, victim_sel;
   logic             any_match;
   logic [31:0]      match_bytes, match_uses;
   logic             need_room;

   assign cand_w[0] = '0;
   assign idx_w[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      bbl_cell #(.INDEX(i), .IW(IW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel[i]),
         .cand_in  (cand_w[i]),
         .idx_in   (idx_w[i]),
         .cand_out (cand_w[i+1]),
         .idx_out  (idx_w[i+1]),
         .valid    (valid_w[i]),
         .match    (match_w[i]),
         .bytes    (bytes_w[i]),
         .uses     (uses_w[i])
      );
   end

   always_comb begin
      match_first = '0;
      free_first  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_w[i]) begin
            match_first = '0;
            match_first[i] = 1'b1;
         end
         if (!valid_w[i]) begin
            free_first = '0;
            free_first[i] = 1'b1;
         end
      end
   end

   always_comb begin
      match_bytes = '0;
      match_uses  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match_bytes = match_bytes | (bytes_w[i] & {32{match_first[i]}});
         match_uses  = match_uses | (uses_w[i] & {32{match_first[i]}});
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         victim_sel[i] = (idx_w[SLOTS] == IW'(i));
      end
   end

   assign any_match = |match_w;
   assign need_room = ({1'b0, byte_total_ff} + {1'b0, req_ff.object_bytes} >
                       {1'b0, budget_ff}) || (entries_ff == EW'(SLOTS));

   always_comb begin
      state_in      = state_ff;
      byte_total_in = byte_total_ff;
      entries_in    = entries_ff;
      use_clock_in  = use_clock_ff;
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      hit_in        = hit_ff;
      stored_in     = stored_ff;
      evicted_in    = evicted_ff;
      use_out_in    = use_out_ff;
      cnt_in        = cnt_ff;
      strobe_in     = 1'b0;
      ctl.cmd       = CELL_IDLE;
      ctl.key       = req_ff.key_tag;
      ctl.bytes     = req_ff.object_bytes;
      ctl.stamp     = use_clock_ff;
      sel           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_EXEC;
               hit_in     = 1'b0;
               stored_in  = 1'b0;
               evicted_in = '0;
               use_out_in = '0;
            end
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            case (req_ff.operation)
               OP_GET: begin
                  if (any_match) begin
                     ctl.cmd      = CELL_TOUCH;
                     sel          = match_first;
                     use_clock_in = use_clock_ff + 64'd1;
                     hit_in       = 1'b1;
                     use_out_in   = (&match_uses) ? match_uses : match_uses + 32'd1;
                     if (!(&hit_total_ff)) hit_total_in = hit_total_ff + 32'd1;
                  end else if (!(&miss_total_ff)) begin
                     miss_total_in = miss_total_ff + 32'd1;
                  end
               end
               OP_PUT: begin
                  if (req_ff.object_bytes <= budget_ff) begin
                     state_in  = ST_CHECK;
                     strobe_in = 1'b0;
                     if (any_match) begin
                        ctl.cmd       = CELL_DROP;
                        sel           = match_first;
                        byte_total_in = byte_total_ff - match_bytes;
                        entries_in    = entries_ff - EW'(1);
                     end
                  end
               end
               OP_CONTAINS: hit_in = any_match;
               OP_CLEAR: begin
                  ctl.cmd       = CELL_CLEAR;
                  byte_total_in = '0;
                  entries_in    = '0;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CHECK: begin
            if (need_room) begin
               if (entries_ff != '0) begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
               end else begin
                  state_in  = ST_IDLE;
                  strobe_in = 1'b1;
               end
            end else begin
               ctl.cmd       = CELL_INSERT;
               sel           = free_first;
               use_clock_in  = use_clock_ff + 64'd1;
               byte_total_in = byte_total_ff + req_ff.object_bytes;
               entries_in    = entries_ff + EW'(1);
               stored_in     = 1'b1;
               state_in      = ST_IDLE;
               strobe_in     = 1'b1;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == IW'(SLOTS - 1)) begin
               ctl.cmd       = CELL_DROP;
               sel           = victim_sel;
               byte_total_in = byte_total_ff - cand_w[SLOTS].bytes;
               entries_in    = entries_ff - EW'(1);
               if (evicted_ff != EVICT_MAX) evicted_in = evicted_ff + 5'd1;
               state_in      = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         budget_ff     <= BUDGET_RESET;
         byte_total_ff <= '0;
         entries_ff    <= '0;
         use_clock_ff  <= '0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         hit_ff        <= 1'b0;
         stored_ff     <= 1'b0;
         evicted_ff    <= '0;
         use_out_ff    <= '0;
         cnt_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_enable) budget_ff <= csr_write_data;
         byte_total_ff <= byte_total_in;
         entries_ff    <= entries_in;
         use_clock_ff  <= use_clock_in;
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
         hit_ff        <= hit_in;
         stored_ff     <= stored_in;
         evicted_ff    <= evicted_in;
         use_out_ff    <= use_out_in;
         cnt_ff        <= cnt_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_payload;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   always_comb begin
      rsp_payload.hit             = hit_ff;
      rsp_payload.stored          = stored_ff;
      rsp_payload.evicted_count   = evicted_ff;
      rsp_payload.entry_use_count = use_out_ff;
      rsp_payload.hit_total       = hit_total_ff;
      rsp_payload.miss_total      = miss_total_ff;
      rsp_payload.bytes_in_use    = byte_total_ff;
      rsp_payload.entries_in_use  = (32'(entries_ff) > 32'd31) ? 5'd31 : 5'(entries_ff);
   end

   `BBL_ASSERT(a_entries_bound, entries_ff <= EW'(SLOTS))
   `BBL_ASSERT_NEXT(a_strobe_single, strobe_ff, !strobe_ff)
   `BBL_ASSERT_IMPL(a_victim_valid, state_ff == ST_SCAN && cnt_ff == IW'(SLOTS - 1), cand_w[SLOTS].valid)
   `BBL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe_ff)
   `BBL_ASSERT_IMPL(a_insert_free, state_ff == ST_CHECK && !need_room, free_first != '0)

endmodule

// File: sim/tb_byte_budget_lfu_cache_policy_core.sv
// Self-checking testbench for the byte budget LFU cache policy core.
// Drives directed and random get, put, contains and clear commands, predicts every result
// with a local model of the table, and depends only on bbl_pkg and the core itself.
module tb_byte_budget_lfu_cache_policy_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bbl_pkg::*;

   localparam int NSLOT = 16;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_payload;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_write_enable;
   logic [31:0] csr_write_data;

   byte_budget_lfu_cache_policy_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   logic        line_valid [NSLOT];
   logic [63:0] line_key   [NSLOT];
   logic [31:0] line_bytes [NSLOT];
   logic [31:0] line_uses  [NSLOT];
   logic [63:0] line_stamp [NSLOT];
   logic [63:0] use_clock_m;
   logic [31:0] hits_m;
   logic [31:0] misses_m;
   logic [31:0] bytes_m;
   logic [31:0] budget_m;

   rsp_type pending_rsp [$];
   int fail_count;
   int sender_idle_pct;
   int cycle_count;
   logic [63:0] key_pool [24];

   function automatic int find_line(logic [63:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (line_valid[i] && line_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int first_free_line();
      for (int i = 0; i < NSLOT; i++)
         if (!line_valid[i]) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type o;
      int s;
      int v;
      int n;
      o = '0;
      case (r.operation)
         OP_GET: begin
            s = find_line(r.key_tag);
            if (s >= 0) begin
               if (line_uses[s] != SAT32) line_uses[s]++;
               line_stamp[s] = use_clock_m;
               use_clock_m++;
               if (hits_m != SAT32) hits_m++;
               o.hit = 1'b1;
               o.entry_use_count = line_uses[s];
            end else if (misses_m != SAT32) begin
               misses_m++;
            end
         end
         OP_PUT: begin
            if (r.object_bytes <= budget_m) begin
               s = find_line(r.key_tag);
               if (s >= 0) begin
                  line_valid[s] = 1'b0;
                  bytes_m -= line_bytes[s];
               end
               while (64'(bytes_m) + 64'(r.object_bytes) > 64'(budget_m)
                      || first_free_line() < 0) begin
                  v = -1;
                  for (int i = 0; i < NSLOT; i++)
                     if (line_valid[i] && (v < 0 || line_uses[i] < line_uses[v] ||
                         (line_uses[i] == line_uses[v] && line_stamp[i] < line_stamp[v])))
                        v = i;
                  if (v < 0) break;
                  line_valid[v] = 1'b0;
                  bytes_m -= line_bytes[v];
                  if (o.evicted_count < EVICT_MAX) o.evicted_count++;
               end
               s = first_free_line();
               if (s >= 0 && 64'(bytes_m) + 64'(r.object_bytes) <= 64'(budget_m)) begin
                  line_valid[s] = 1'b1;
                  line_key[s] = r.key_tag;
                  line_bytes[s] = r.object_bytes;
                  line_uses[s] = 32'd1;
                  line_stamp[s] = use_clock_m;
                  use_clock_m++;
                  bytes_m += r.object_bytes;
                  o.stored = 1'b1;
               end
            end
         end
         OP_CONTAINS: o.hit = (find_line(r.key_tag) >= 0);
         default: begin
            for (int i = 0; i < NSLOT; i++) line_valid[i] = 1'b0;
            bytes_m = '0;
         end
      endcase
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (line_valid[i]) n++;
      if (n > 31) n = 31;
      o.hit_total = hits_m;
      o.miss_total = misses_m;
      o.bytes_in_use = bytes_m;
      o.entries_in_use = 5'(n);
      return o;
   endfunction

   // Start is left high after a transfer without a gap; whoever runs next either
   // drives a new command or lowers start in that same step.
   task automatic send_command(op_type op, logic [63:0] k, logic [31:0] b);
      req_type r;
      r.operation = op;
      r.key_tag = k;
      r.object_bytes = b;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_access(r));
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(logic [31:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      budget_m = value;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: actual %p", $time, rsp_payload);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.hit !== want.hit || rsp_payload.stored !== want.stored ||
                rsp_payload.evicted_count !== want.evicted_count ||
                rsp_payload.entry_use_count !== want.entry_use_count ||
                rsp_payload.hit_total !== want.hit_total ||
                rsp_payload.miss_total !== want.miss_total ||
                rsp_payload.bytes_in_use !== want.bytes_in_use ||
                rsp_payload.entries_in_use !== want.entries_in_use) begin
               $display("%0t mismatch: expected %p actual %p", $time, want, rsp_payload);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_byte_budget_lfu_cache_policy_core NOT OK");
         $finish;
      end
   end

   task automatic test_lookup_basics();
      send_command(OP_GET, 64'd0, 32'd0);
      send_command(OP_CONTAINS, SAT32 & 64'd5, 32'hFFFF_FFFF);
      send_command(OP_PUT, 64'd0, 32'd0);
      send_command(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1048576);
      send_command(OP_PUT, 64'd7, 32'hFFFF_FFFF);
      send_command(OP_GET, 64'd0, 32'd0);
      send_command(OP_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
      send_command(OP_PUT, 64'd0, 32'd100);
      send_command(OP_CLEAR, 64'd0, 32'd0);
      send_command(OP_CONTAINS, 64'd0, 32'd0);
   endtask

   task automatic test_slot_eviction();
      for (int i = 0; i < 16; i++) send_command(OP_PUT, 64'(i + 100), 32'd16);
      send_command(OP_GET, 64'd100, 32'd0);
      send_command(OP_PUT, 64'd200, 32'd16);
      send_command(OP_PUT, 64'd201, 32'd16);
   endtask

   task automatic test_budget_eviction();
      write_budget(32'd64);
      send_command(OP_PUT, 64'd300, 32'd64);
      write_budget(32'd0);
      send_command(OP_PUT, 64'd301, 32'd1);
      send_command(OP_PUT, 64'd302, 32'd0);
      write_budget(32'hFFFF_FFFF);
      send_command(OP_PUT, 64'd303, 32'hFFFF_FFFF);
      send_command(OP_PUT, 64'd304, 32'd1);
   endtask

   task automatic test_random(int count, int idle_pct, int max_bytes);
      int pick;
      logic [63:0] k;
      logic [31:0] b;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         k = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(23)];
         b = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(max_bytes));
         if (pick < 40) send_command(OP_GET, k, b);
         else if (pick < 78) send_command(OP_PUT, k, b);
         else if (pick < 97) send_command(OP_CONTAINS, k, b);
         else send_command(OP_CLEAR, k, b);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      fail_count = 0;
      cycle_count = 0;
      sender_idle_pct = 33;
      for (int i = 0; i < NSLOT; i++) line_valid[i] = 1'b0;
      use_clock_m = '0;
      hits_m = '0;
      misses_m = '0;
      bytes_m = '0;
      budget_m = BUDGET_RESET;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 24; i++) key_pool[i] = {$urandom, $urandom};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lookup_basics();
      test_slot_eviction();
      test_budget_eviction();
      write_budget(32'd4096);
      test_random(300, 33, 1024);
      write_budget(32'hFFFF_FFFF);
      test_random(300, 65, 32'h3FFF_FFFF);
      write_budget(32'd300);
      test_random(150, 0, 120);
      write_budget(32'd0);
      test_random(40, 0, 2);
      write_budget(BUDGET_RESET);
      test_random(110, 0, 200000);
      drain_results();

      if (fail_count == 0)
         $display("tb_byte_budget_lfu_cache_policy_core OK");
      else
         $display("tb_byte_budget_lfu_cache_policy_core NOT OK");
      $finish;
   end
endmodule
